// File: design/assert_macros.svh
// Assertion macros shared by the MD5 engine RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: design/md5_pkg.sv
// Package for the MD5 engine: types, initial values, round constants and schedules.
// No dependencies.
package md5_pkg;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_words_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_ADD
  } md5_state_e;

  localparam logic [31:0] IvA = 32'h67452301;
  localparam logic [31:0] IvB = 32'hefcdab89;
  localparam logic [31:0] IvC = 32'h98badcfe;
  localparam logic [31:0] IvD = 32'h10325476;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;
  localparam logic [5:0] LastPos = 6'd63;

  localparam logic [31:0] RoundK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'h0: s = 5'd7;
      4'h1: s = 5'd12;
      4'h2: s = 5'd17;
      4'h3: s = 5'd22;
      4'h4: s = 5'd5;
      4'h5: s = 5'd9;
      4'h6: s = 5'd14;
      4'h7: s = 5'd20;
      4'h8: s = 5'd4;
      4'h9: s = 5'd11;
      4'ha: s = 5'd16;
      4'hb: s = 5'd23;
      4'hc: s = 5'd6;
      4'hd: s = 5'd10;
      4'he: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] r;
    logic [3:0] g;
    r = rnd[3:0];
    case (rnd[5:4])
      2'd0: g = r;
      2'd1: g = 4'(r * 4'd5) + 4'd1;
      2'd2: g = 4'(r * 4'd3) + 4'd5;
      default: g = 4'(r * 4'd7);
    endcase
    return g;
  endfunction

endpackage

// File: design/md5_ifs.sv
// Handshake channels of the MD5 engine: message byte requests and digest results.
// No dependencies.
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       message_end;

  modport source (output valid, data_byte, byte_present, message_end, input ready);
  modport sink (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_a;
  logic [31:0] digest_b;
  logic [31:0] digest_c;
  logic [31:0] digest_d;

  modport source (output valid, digest_a, digest_b, digest_c, digest_d, input ready);
  modport sink (input valid, digest_a, digest_b, digest_c, digest_d, output ready);
endinterface

// File: design/md5_hash_engine.sv
// Top level of the byte-serial MD5 engine.
// Depends on md5_pkg, md5_ifs, md5_round and assert_macros.svh.
`include "assert_macros.svh"

// Message bytes are taken one per cycle while idle, until a 64-byte block is full. A
// full block is compressed by one shared round unit, one round per cycle (load, 64
// rounds, final add) during which no request is taken. A request that ends the message
// adds padding written one byte per cycle up to the end of the block (64 minus the fill
// count) and one more compression, or a second padded block and compression when 56 or
// more bytes were pending. The digest waits in an output register; new bytes are taken
// while it waits, and the next digest stalls at its final add until the previous one
// has been taken. After a digest the engine is back at the initial chaining values.
module md5_hash_engine (
  input  logic clk_i,
  input  logic rst_ni,
  md5_in_if.sink    in_i,
  md5_out_if.source out_o
);
  import md5_pkg::*;

  md5_state_e  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bitlen_q, bitlen_d;
  md5_words_t  chain_q, chain_d;
  md5_words_t  work_q, work_d;
  md5_words_t  digest_q, digest_d;
  md5_words_t  round_out;
  md5_words_t  sum;
  logic [5:0]  rnd_q, rnd_d;
  logic [5:0]  pad_idx_q, pad_idx_d;
  logic        pad_first_q, pad_first_d;
  logic        final_q, final_d;
  logic        end_pend_q, end_pend_d;
  logic        out_valid_q, out_valid_d;
  logic [5:0]  fill_next;
  logic        last_round;
  logic        digest_fire;
  logic        restarted;

  logic [31:0] words_q [16];
  logic        buf_we;
  logic [5:0]  buf_addr;
  logic [7:0]  buf_byte;

  md5_round u_round (
    .st_i  (work_q),
    .w_i   (words_q[msg_index(rnd_q)]),
    .rnd_i (rnd_q),
    .st_o  (round_out)
  );

  always_comb begin
    sum.a = chain_q.a + work_q.a;
    sum.b = chain_q.b + work_q.b;
    sum.c = chain_q.c + work_q.c;
    sum.d = chain_q.d + work_q.d;
  end

  assign in_i.ready     = (state_q == ST_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.digest_a = digest_q.a;
  assign out_o.digest_b = digest_q.b;
  assign out_o.digest_c = digest_q.c;
  assign out_o.digest_d = digest_q.d;

  assign last_round  = (state_q == ST_ROUND) && (rnd_q == LastPos);
  assign digest_fire = (state_q == ST_ADD) && final_q && (!out_valid_q || out_o.ready);
  assign restarted   = (state_q == ST_IDLE) && (fill_q == 6'd0) && (bitlen_q == 64'd0);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    bitlen_d    = bitlen_q;
    chain_d     = chain_q;
    work_d      = work_q;
    digest_d    = digest_q;
    rnd_d       = rnd_q;
    pad_idx_d   = pad_idx_q;
    pad_first_d = pad_first_q;
    final_d     = final_q;
    end_pend_d  = end_pend_q;
    out_valid_d = out_valid_q && !out_o.ready;
    buf_we      = 1'b0;
    buf_addr    = fill_q;
    buf_byte    = in_i.data_byte;
    fill_next   = in_i.byte_present ? fill_q + 6'd1 : fill_q;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          final_d    = 1'b0;
          end_pend_d = in_i.message_end;
          if (in_i.byte_present) begin
            buf_we   = 1'b1;
            fill_d   = fill_next;
            bitlen_d = bitlen_q + 64'd8;
          end
          if (in_i.byte_present && fill_q == LastPos) begin
            state_d = ST_LOAD;
          end else if (in_i.message_end) begin
            state_d     = ST_PAD;
            pad_idx_d   = fill_next;
            pad_first_d = 1'b1;
            final_d     = (fill_next < LenPos);
          end
        end
      end
      ST_PAD: begin
        buf_we   = 1'b1;
        buf_addr = pad_idx_q;
        if (pad_first_q) begin
          buf_byte = PadByte;
        end else if (final_q && pad_idx_q >= LenPos) begin
          buf_byte = bitlen_q[{pad_idx_q[2:0], 3'b000} +: 8];
        end else begin
          buf_byte = 8'h00;
        end
        pad_first_d = 1'b0;
        pad_idx_d   = pad_idx_q + 6'd1;
        if (pad_idx_q == LastPos) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        work_d  = chain_q;
        rnd_d   = 6'd0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        work_d = round_out;
        rnd_d  = rnd_q + 6'd1;
        if (rnd_q == LastPos) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        if (final_q) begin
          if (!out_valid_q || out_o.ready) begin
            digest_d    = sum;
            out_valid_d = 1'b1;
            chain_d     = '{a: IvA, b: IvB, c: IvC, d: IvD};
            fill_d      = 6'd0;
            bitlen_d    = 64'd0;
            final_d     = 1'b0;
            end_pend_d  = 1'b0;
            state_d     = ST_IDLE;
          end
        end else begin
          chain_d = sum;
          if (end_pend_q) begin
            state_d     = ST_PAD;
            pad_idx_d   = 6'd0;
            pad_first_d = (fill_q == 6'd0);
            final_d     = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= 6'd0;
      bitlen_q    <= 64'd0;
      chain_q     <= '{a: IvA, b: IvB, c: IvC, d: IvD};
      rnd_q       <= 6'd0;
      pad_idx_q   <= 6'd0;
      pad_first_q <= 1'b0;
      final_q     <= 1'b0;
      end_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      bitlen_q    <= bitlen_d;
      chain_q     <= chain_d;
      rnd_q       <= rnd_d;
      pad_idx_q   <= pad_idx_d;
      pad_first_q <= pad_first_d;
      final_q     <= final_d;
      end_pend_q  <= end_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q   <= work_d;
    digest_q <= digest_d;
    if (buf_we) begin
      words_q[buf_addr[5:2]][{buf_addr[1:0], 3'b000} +: 8] <= buf_byte;
    end
  end

  `ASSERT_IMPLY(idle_not_final_a, state_q == ST_IDLE, !final_q, "Final flag left set while idle.")
  `ASSERT_NEXT(round_end_a, last_round, state_q == ST_ADD, "Last round did not lead to the add.")
  `ASSERT_NEXT(digest_restart_a, digest_fire, out_valid_q && restarted, "Digest without restart.")

endmodule

// File: design/md5_round.sv
// One MD5 round step, shared by all 64 rounds of a compression.
// Depends on md5_pkg.
module md5_round (
  input  md5_pkg::md5_words_t st_i,
  input  logic [31:0]         w_i,
  input  logic [5:0]          rnd_i,
  output md5_pkg::md5_words_t st_o
);
  import md5_pkg::*;

  logic [31:0] f;
  logic [31:0] t;
  logic [63:0] rot;

  always_comb begin
    case (rnd_i[5:4])
      2'd0: f = (st_i.b & st_i.c) | (~st_i.b & st_i.d);
      2'd1: f = (st_i.b & st_i.d) | (st_i.c & ~st_i.d);
      2'd2: f = st_i.b ^ st_i.c ^ st_i.d;
      default: f = st_i.c ^ (st_i.b | ~st_i.d);
    endcase
    t = st_i.a + f + RoundK[rnd_i] + w_i;
    rot = {t, t} << rot_amount(rnd_i);
    st_o.a = st_i.d;
    st_o.b = st_i.b + rot[63:32];
    st_o.c = st_i.b;
    st_o.d = st_i.c;
  end

endmodule
